@@ rtl/core/spt_pkg.sv @@
// Shared types, constants and helpers of the stride prefetch table.
`default_nettype none

package spt_pkg;

    localparam int PC_W        = 32;
    localparam int DATA_W      = 32;
    localparam int STEP_W      = 13;
    localparam int REQ_W       = 5;
    localparam int CNT_W       = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_STEP = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUESTS   = 1'b1;

    localparam logic [STEP_W-1:0] BLOCK_STEP_RESET = 13'd32;
    localparam logic [REQ_W-1:0]  REQUESTS_RESET   = 5'd4;
    localparam logic [REQ_W-1:0]  REQUESTS_MAX     = 5'd16;

    // Operation codes of an input item
    localparam logic OP_ACCESS   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Row index reduction: bits of the PC folded in per cycle
    localparam int ROW_BITS_PER_STEP = 4;
    localparam int ROW_STEPS         = PC_W / ROW_BITS_PER_STEP;
    localparam int ROW_STEP_CNT_W    = $clog2(ROW_STEPS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic            op;
        logic [PC_W-1:0] pc;
        logic [DATA_W-1:0] addr;
        logic            hit;
    } spt_item_t;

    // Saturate the request count to 1..16 and return it minus one
    function automatic logic [CNT_W-1:0] count_minus_one(input logic [REQ_W-1:0] req);
        logic [CNT_W-1:0] res;
        if (req == '0)
            res = '0;
        else if (req > REQUESTS_MAX)
            res = CNT_W'(REQUESTS_MAX - 5'd1);
        else
            res = CNT_W'(req - 5'd1);
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/spt_front.sv @@
// Front end: accepts items and reduces the PC to a table row.
`default_nettype none

module spt_front #(
    parameter int TABLE_ENTRIES = 256,
    parameter int IDX_W         = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    hold,
    input  wire logic                    q_full,
    input  wire logic                    op,
    input  wire logic [spt_pkg::PC_W-1:0]   access_pc,
    input  wire logic [spt_pkg::DATA_W-1:0] access_addr,
    input  wire logic                    hit_l1,
    output logic                         busy,
    output logic                         push,
    output spt_pkg::spt_item_t           item,
    output logic [IDX_W-1:0]             row
);
    import spt_pkg::*;

    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [IDX_W:0]  ENTRIES_W = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [PC_W-1:0] ROW_MASK  = PC_W'(TABLE_ENTRIES - 1);
    localparam logic [ROW_STEP_CNT_W-1:0] STEPS_LOAD =
        IS_POW2 ? '0 : ROW_STEP_CNT_W'(ROW_STEPS);

    logic                      fr_valid_reg, fr_valid_next;
    spt_item_t                 item_reg, item_next;
    logic [PC_W-1:0]           bits_reg, bits_next;
    logic [IDX_W-1:0]          rem_reg, rem_next;
    logic [ROW_STEP_CNT_W-1:0] steps_reg, steps_next;
    logic [IDX_W-1:0]          rem_work;
    logic [IDX_W:0]            trial;
    logic [IDX_W-1:0]          rem_calc;
    logic                      accept;

    // Fold a few PC bits into the running remainder, MSB first
    always_comb
    begin
        rem_work = rem_reg;
        trial    = '0;
        for (int k = 0; k < ROW_BITS_PER_STEP; k++)
        begin
            trial = {rem_work, bits_reg[PC_W-1-k]};
            if (trial >= ENTRIES_W)
                trial = trial - ENTRIES_W;
            rem_work = trial[IDX_W-1:0];
        end
        rem_calc = rem_work;
    end

    assign push   = fr_valid_reg && (steps_reg == '0) && !q_full;
    assign busy   = hold || (fr_valid_reg && !push);
    assign accept = start && !busy;
    assign item   = item_reg;
    assign row    = IS_POW2 ? IDX_W'(item_reg.pc & ROW_MASK) : rem_reg;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        item_next     = item_reg;
        bits_next     = bits_reg;
        rem_next      = rem_reg;
        steps_next    = steps_reg;
        if (accept)
        begin
            fr_valid_next = 1'b1;
            item_next     = '{op: op, pc: access_pc, addr: access_addr, hit: hit_l1};
            bits_next     = access_pc;
            rem_next      = '0;
            steps_next    = STEPS_LOAD;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
        else if (fr_valid_reg && (steps_reg != '0))
        begin
            rem_next   = rem_calc;
            bits_next  = bits_reg << ROW_BITS_PER_STEP;
            steps_next = steps_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
            steps_reg    <= '0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
            steps_reg    <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        bits_reg <= bits_next;
        rem_reg  <= rem_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/spt_queue.sv @@
// Short queue of classified items between front and back.
`default_nettype none

module spt_queue #(
    parameter int IDX_W = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire spt_pkg::spt_item_t push_item,
    input  wire logic [IDX_W-1:0]   push_row,
    input  wire logic               pop,
    output logic                    full,
    output logic                    not_empty,
    output spt_pkg::spt_item_t      head_item,
    output logic [IDX_W-1:0]        head_row
);
    import spt_pkg::*;

    spt_item_t          item_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0]   row_mem  [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign full      = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_item = item_mem[rd_ptr_reg];
    assign head_row  = row_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[wr_ptr_reg] <= push_item;
            row_mem[wr_ptr_reg]  <= push_row;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/spt_back.sv @@
// Back end: table clear, table lookup and update, prefetch sequencing.
`default_nettype none

module spt_back #(
    parameter int TABLE_ENTRIES = 256,
    parameter int ADDR_BITS     = 32,
    parameter int IDX_W         = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_not_empty,
    input  wire spt_pkg::spt_item_t            head_item,
    input  wire logic [IDX_W-1:0]              head_row,
    input  wire logic [spt_pkg::STEP_W-1:0]    block_step,
    input  wire logic [spt_pkg::REQ_W-1:0]     requests_per_trigger,
    output logic                               pop,
    output logic                               clearing,
    output logic                               done,
    output logic                               prefetch_valid,
    output logic [spt_pkg::DATA_W-1:0]         prefetch_addr
);
    import spt_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [PC_W-1:0]      tag;
        logic [ADDR_BITS-1:0] stride;
        logic [ADDR_BITS-1:0] last;
    } spt_row_t;

    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(TABLE_ENTRIES - 1);

    spt_row_t table_mem [TABLE_ENTRIES];
    spt_row_t rd_data_reg;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_idx_reg, clr_idx_next;
    spt_item_t            cur_item_reg, cur_item_next;
    logic [IDX_W-1:0]     cur_row_reg, cur_row_next;
    logic                 pend_flag_reg, pend_flag_next;
    logic [ADDR_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic [PC_W-1:0]      pend_pc_reg, pend_pc_next;
    logic [IDX_W-1:0]     pend_row_reg, pend_row_next;
    logic [CNT_W-1:0]     rem_cnt_reg, rem_cnt_next;
    logic                 done_reg, done_next;
    logic                 pf_valid_reg, pf_valid_next;
    logic [DATA_W-1:0]    pf_addr_reg, pf_addr_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     wr_addr;
    spt_row_t             wr_data;
    logic [IDX_W-1:0]     rd_addr;

    logic [ADDR_BITS-1:0] addr_in;
    logic [ADDR_BITS-1:0] blk;
    logic [ADDR_BITS-1:0] diff;
    logic [ADDR_BITS-1:0] known_step;
    logic [ADDR_BITS-1:0] miss_step;
    logic                 tag_match;

    assign pop            = (state_reg == ST_IDLE) && q_not_empty;
    assign clearing       = state_reg == ST_CLEAR;
    assign rd_addr        = (head_item.op == OP_COMPLETE) ? pend_row_reg : head_row;
    assign done           = done_reg;
    assign prefetch_valid = pf_valid_reg;
    assign prefetch_addr  = pf_addr_reg;

    assign addr_in    = ADDR_BITS'(cur_item_reg.addr);
    assign blk        = ADDR_BITS'(block_step);
    assign tag_match  = rd_data_reg.tag ==
                        ((cur_item_reg.op == OP_COMPLETE) ? pend_pc_reg : cur_item_reg.pc);
    assign diff       = addr_in - rd_data_reg.last;
    assign known_step = tag_match ? rd_data_reg.stride : blk;
    assign miss_step  = (tag_match && (diff == rd_data_reg.stride)) ? diff : blk;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[wr_addr] <= wr_data;
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        cur_item_next  = cur_item_reg;
        cur_row_next   = cur_row_reg;
        pend_flag_next = pend_flag_reg;
        pend_addr_next = pend_addr_reg;
        pend_pc_next   = pend_pc_reg;
        pend_row_next  = pend_row_reg;
        rem_cnt_next   = rem_cnt_reg;
        done_next      = 1'b0;
        pf_valid_next  = pf_valid_reg;
        pf_addr_next   = pf_addr_reg;
        mem_we         = 1'b0;
        wr_addr        = cur_row_reg;
        wr_data        = '{tag: cur_item_reg.pc,
                           stride: (tag_match ? diff : '0),
                           last: addr_in};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_ROW)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    cur_item_next = head_item;
                    cur_row_next  = head_row;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (cur_item_reg.op == OP_COMPLETE)
                begin
                    if (pend_flag_reg)
                    begin
                        if (rem_cnt_reg == '0)
                            pend_flag_next = 1'b0;
                        else
                        begin
                            rem_cnt_next   = rem_cnt_reg - 1'b1;
                            pend_addr_next = pend_addr_reg + known_step;
                        end
                    end
                end
                else if (cur_item_reg.hit)
                begin
                    if (!pend_flag_reg)
                    begin
                        pend_addr_next = addr_in + known_step;
                        pend_pc_next   = cur_item_reg.pc;
                        pend_row_next  = cur_row_reg;
                        pend_flag_next = 1'b1;
                        rem_cnt_next   = count_minus_one(requests_per_trigger);
                    end
                end
                else
                begin
                    mem_we         = 1'b1;
                    pend_addr_next = addr_in + miss_step;
                    pend_pc_next   = cur_item_reg.pc;
                    pend_row_next  = cur_row_reg;
                    pend_flag_next = 1'b1;
                    rem_cnt_next   = count_minus_one(requests_per_trigger);
                end
                pf_valid_next = pend_flag_next;
                pf_addr_next  = pend_flag_next ? DATA_W'(pend_addr_next) : '0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            cur_item_reg  <= '0;
            cur_row_reg   <= '0;
            pend_flag_reg <= 1'b0;
            pend_addr_reg <= '0;
            pend_pc_reg   <= '0;
            pend_row_reg  <= '0;
            rem_cnt_reg   <= '0;
            done_reg      <= 1'b0;
            pf_valid_reg  <= 1'b0;
            pf_addr_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            cur_item_reg  <= cur_item_next;
            cur_row_reg   <= cur_row_next;
            pend_flag_reg <= pend_flag_next;
            pend_addr_reg <= pend_addr_next;
            pend_pc_reg   <= pend_pc_next;
            pend_row_reg  <= pend_row_next;
            rem_cnt_reg   <= rem_cnt_next;
            done_reg      <= done_next;
            pf_valid_reg  <= pf_valid_next;
            pf_addr_reg   <= pf_addr_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/stride_prefetch_table_top.sv @@
// Top level of the stride prefetch table: config registers, front, queue, back.
//
//  channel   | signals                                   | transfer when
//  ----------+-------------------------------------------+-------------------------
//  request   | start, busy, op, access_pc, access_addr,  | start high, busy low
//            | hit_l1                                    |
//  result    | done, prefetch_valid, prefetch_addr       | done high (one cycle)
//  config    | cfg_we, cfg_index, cfg_data               | cfg_we high
//
//  The back end reads the table row for an item in ST_IDLE and updates it and
//  the prefetch state in ST_EXEC; it takes no new item while in ST_EXEC.
//  The front end reduces the PC to a row by masking for a power-of-two table,
//  else by folding PC bits into a remainder; a two-entry queue lets it run ahead.
//  After reset the table is cleared one row per cycle, all TABLE_ENTRIES rows,
//  with busy held high; config writes are taken during that time.
//  The receiver cannot stall: each result is shown on done for exactly one cycle.
`default_nettype none

module stride_prefetch_table_top #(
    parameter int TABLE_ENTRIES = 256,
    parameter int ADDR_BITS     = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                op,
    input  wire logic [spt_pkg::PC_W-1:0]            access_pc,
    input  wire logic [spt_pkg::DATA_W-1:0]          access_addr,
    input  wire logic                                hit_l1,
    output logic                                     done,
    output logic                                     prefetch_valid,
    output logic [spt_pkg::DATA_W-1:0]               prefetch_addr,
    input  wire logic                                cfg_we,
    input  wire logic [spt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [spt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import spt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [STEP_W-1:0] block_step_reg, block_step_next;
    logic [REQ_W-1:0]  requests_reg, requests_next;

    logic              clearing;
    logic              q_full;
    logic              q_not_empty;
    logic              push;
    logic              pop;
    spt_item_t         fr_item;
    logic [IDX_W-1:0]  fr_row;
    spt_item_t         head_item;
    logic [IDX_W-1:0]  head_row;

    // Configuration: write the addressed register, drop unknown indexes
    always_comb
    begin
        block_step_next = block_step_reg;
        requests_next   = requests_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_STEP: block_step_next = cfg_data[STEP_W-1:0];
                REG_REQUESTS:   requests_next   = cfg_data[REQ_W-1:0];
                default:        block_step_next = block_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_step_reg <= BLOCK_STEP_RESET;
            requests_reg   <= REQUESTS_RESET;
        end
        else
        begin
            block_step_reg <= block_step_next;
            requests_reg   <= requests_next;
        end
    end

    // Front end: take the item, hold it while its row index is worked out
    spt_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .hold        (clearing),
        .q_full      (q_full),
        .op          (op),
        .access_pc   (access_pc),
        .access_addr (access_addr),
        .hit_l1      (hit_l1),
        .busy        (busy),
        .push        (push),
        .item        (fr_item),
        .row         (fr_row)
    );

    // Decouple front and back so each can stall on its own
    spt_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (fr_item),
        .push_row  (fr_row),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_item (head_item),
        .head_row  (head_row)
    );

    // Back end: table lookup and update, pending request sequencing, result
    spt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS),
        .IDX_W         (IDX_W)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .q_not_empty          (q_not_empty),
        .head_item            (head_item),
        .head_row             (head_row),
        .block_step           (block_step_reg),
        .requests_per_trigger (requests_reg),
        .pop                  (pop),
        .clearing             (clearing),
        .done                 (done),
        .prefetch_valid       (prefetch_valid),
        .prefetch_addr        (prefetch_addr)
    );

endmodule

`default_nettype wire

@@ rtl/core/spt_checker.sv @@
// Port-level checks of the stride prefetch table, bound to the top level.
`default_nettype none

module spt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        done,
    input wire logic                        prefetch_valid,
    input wire logic [spt_pkg::DATA_W-1:0]  prefetch_addr
);
    import spt_pkg::*;

    // Front holds one, queue QUEUE_DEPTH, back one
    localparam logic [2:0] OUT_MAX = 3'(QUEUE_DEPTH + 2);

    logic [2:0] out_cnt_reg, out_cnt_next;
    logic       acc;

    assign acc = start && !busy;

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (acc && !done)
            out_cnt_next = out_cnt_reg + 3'd1;
        else if (done && !acc)
            out_cnt_next = out_cnt_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_cnt_reg <= '0;
        else
            out_cnt_reg <= out_cnt_next;
    end

    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on two adjacent cycles");

    a_idle_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !prefetch_valid) |-> (prefetch_addr == '0))
        else $error("idle result carries a nonzero address");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_cnt_reg != 3'd0))
        else $error("result without an outstanding item");

    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_cnt_reg >= OUT_MAX) |-> busy)
        else $error("item taken with every stage occupied");

endmodule

bind stride_prefetch_table_top spt_checker u_spt_checker (.*);

`default_nettype wire
